// ===== hw/rtl/mtsg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsg_pkg
// shared constants, codes and controller/datapath interface types for the
// multi-finger scroll gesture recogniser
// ----------------------------------------------------------------------------
`default_nettype none

package mtsg_pkg;

  // number of touch slots
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // field widths
  localparam int KIND_W = 2;
  localparam int SIN_W  = 4;
  localparam int POS_W  = 18;
  localparam int TIME_W = 32;
  localparam int DIR_W  = 2;
  localparam int AMT_W  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;
  localparam int MIN_W      = 10;
  localparam int GF_W       = 5;

  // arithmetic widths
  localparam int SUM_W = 24;
  localparam int DEL_W = POS_W + 1;
  localparam int ACC_W = DEL_W + SLOT_W + 1;
  localparam int SQ_W  = 2 * SUM_W;
  localparam int DTC_W = TIME_W + CNT_W;
  localparam int DEN_W = DTC_W + 9;
  localparam int LIM_W = CNT_W + 4 + THR_W;
  localparam int QB_W  = 5;
  localparam int TRL_W = DEN_W + QB_W;
  localparam int BIT_W = 3;

  localparam logic [AMT_W-1:0] AMOUNT_MAX = 4'd15;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINGERS    = 2'd3;

  // scroll directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  // shared multiplier operand select
  localparam logic [1:0] MUL_SQX = 2'd0;
  localparam logic [1:0] MUL_SQY = 2'd1;
  localparam logic [1:0] MUL_TSQ = 2'd2;

  typedef struct packed {
    logic              ev_load;
    logic              do_down;
    logic              do_up;
    logic              rd_ev;
    logic              do_move;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              act_cmp;
    logic              walk_clr;
    logic              walk_rd;
    logic [SLOT_W-1:0] walk_idx;
    logic              dtc_en;
    logic              den_en;
    logic              sel_en;
    logic              div_en;
    logic [BIT_W-1:0]  div_bit;
    logic              scr_en;
    logic              out_load;
  } mtsg_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              slot_ok;
    logic              move_ok;
    logic              tmr_ok;
  } mtsg_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mtsg_dp.sv =====
// ----------------------------------------------------------------------------
// mtsg_dp
// datapath: event registers, slot memories, sums, shared multiplier, slot
// walk accumulators, serial quotient unit and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module mtsg_dp
  import mtsg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mtsg_cmd_t             cmd_i,
  output mtsg_sts_t                  sts_o,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [SIN_W-1:0]      slot_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  input  wire logic [TIME_W-1:0]     time_ms_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       scroll_valid_o,
  output logic [DIR_W-1:0]           scroll_direction_o,
  output logic [AMT_W-1:0]           scroll_amount_o,
  output logic                       gesture_active_o
);

  // configuration
  logic [THR_W-1:0] start_thr_q, scroll_thr_q;
  logic [MIN_W-1:0] min_int_q;
  logic [GF_W-1:0]  fingers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q  <= 16'd2560;
      scroll_thr_q <= 16'd128;
      min_int_q    <= 10'd16;
      fingers_q    <= 5'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_THR:  start_thr_q  <= cfg_data_i;
        REG_SCROLL_THR: scroll_thr_q <= cfg_data_i;
        REG_MIN_INT:    min_int_q    <= cfg_data_i[MIN_W-1:0];
        REG_FINGERS:    fingers_q    <= cfg_data_i[GF_W-1:0];
        default: ;
      endcase
    end
  end

  // event registers
  logic [KIND_W-1:0] kind_q;
  logic [SIN_W-1:0]  slot_q;
  logic [POS_W-1:0]  px_q, py_q;
  logic [TIME_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_load) begin
      kind_q <= kind_i;
      slot_q <= slot_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      now_q  <= time_ms_i;
    end
  end

  logic [SLOT_W-1:0] ev_idx;
  assign ev_idx = SLOT_W'(slot_q);

  // control state
  logic [SLOTS-1:0]        present_q, pvalid_q;
  logic [CNT_W-1:0]        count_q;
  logic signed [SUM_W-1:0] sum_dx_q, sum_dy_q;
  logic                    active_q;
  logic [TIME_W-1:0]       last_q;

  // slot memories
  logic [POS_W-1:0] cur_x_mem [SLOTS];
  logic [POS_W-1:0] cur_y_mem [SLOTS];
  logic [POS_W-1:0] prev_x_mem [SLOTS];
  logic [POS_W-1:0] prev_y_mem [SLOTS];
  logic [POS_W-1:0] rd_cx_q, rd_cy_q, rd_px_q, rd_py_q;
  logic [SLOT_W-1:0] rd_addr;

  assign rd_addr = cmd_i.walk_rd ? cmd_i.walk_idx : ev_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_ev || cmd_i.walk_rd) begin
      rd_cx_q <= cur_x_mem[rd_addr];
      rd_cy_q <= cur_y_mem[rd_addr];
      rd_px_q <= prev_x_mem[rd_addr];
      rd_py_q <= prev_y_mem[rd_addr];
    end
  end

  // previous position for a motion event
  logic [POS_W-1:0] mv_px, mv_py;
  assign mv_px = present_q[ev_idx] ? rd_cx_q : px_q;
  assign mv_py = present_q[ev_idx] ? rd_cy_q : py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_down || cmd_i.do_move) begin
      cur_x_mem[ev_idx] <= px_q;
      cur_y_mem[ev_idx] <= py_q;
    end
    if (cmd_i.do_move) begin
      prev_x_mem[ev_idx] <= mv_px;
      prev_y_mem[ev_idx] <= mv_py;
    end
  end

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [DEL_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  logic signed [DEL_W-1:0] mv_dx, mv_dy;
  assign mv_dx = $signed({1'b0, px_q}) - $signed({1'b0, mv_px});
  assign mv_dy = $signed({1'b0, py_q}) - $signed({1'b0, mv_py});

  logic [CNT_W-1:0] cnt_inc, cnt_dec;
  assign cnt_inc = (count_q < CNT_W'(SLOTS)) ? count_q + 1'b1 : count_q;
  assign cnt_dec = (count_q != '0) ? count_q - 1'b1 : count_q;

  // squares for activation
  logic [SUM_W-1:0] mag_x, mag_y, mul_a;
  logic [SQ_W-1:0]  prod, sqx_q, sqy_q, tsq_q;
  assign mag_x = sum_dx_q[SUM_W-1] ? SUM_W'(-sum_dx_q) : SUM_W'(sum_dx_q);
  assign mag_y = sum_dy_q[SUM_W-1] ? SUM_W'(-sum_dy_q) : SUM_W'(sum_dy_q);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQX: mul_a = mag_x;
      MUL_SQY: mul_a = mag_y;
      default: mul_a = SUM_W'(start_thr_q);
    endcase
  end
  assign prod = SQ_W'(mul_a) * SQ_W'(mul_a);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_SQX: sqx_q <= prod;
        MUL_SQY: sqy_q <= prod;
        default: tsq_q <= prod;
      endcase
    end
  end

  logic act_hit;
  assign act_hit = ((SQ_W+1)'(sqx_q) + (SQ_W+1)'(sqy_q)) > (SQ_W+1)'(tsq_q);

  // interval
  logic [TIME_W-1:0] dt, dt_eff;
  assign dt     = now_q - last_q;
  assign dt_eff = (dt == '0) ? TIME_W'(1) : dt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      pvalid_q  <= '0;
      count_q   <= '0;
      sum_dx_q  <= '0;
      sum_dy_q  <= '0;
      active_q  <= 1'b0;
      last_q    <= '0;
    end else begin
      if (cmd_i.do_down) begin
        count_q           <= cnt_inc;
        present_q[ev_idx] <= 1'b1;
        if (cnt_inc == CNT_W'(1)) begin
          sum_dx_q <= '0;
          sum_dy_q <= '0;
        end
      end
      if (cmd_i.do_move) begin
        present_q[ev_idx] <= 1'b1;
        pvalid_q[ev_idx]  <= 1'b1;
        sum_dx_q          <= sat_add(sum_dx_q, mv_dx);
        sum_dy_q          <= sat_add(sum_dy_q, mv_dy);
      end
      if (cmd_i.do_up) begin
        count_q <= cnt_dec;
        if (cnt_dec == '0) begin
          active_q  <= 1'b0;
          sum_dx_q  <= '0;
          sum_dy_q  <= '0;
          present_q <= '0;
          pvalid_q  <= '0;
        end else begin
          present_q[ev_idx] <= 1'b0;
          pvalid_q[ev_idx]  <= 1'b0;
        end
      end
      if (cmd_i.act_cmp && !active_q && act_hit) begin
        active_q <= 1'b1;
        last_q   <= now_q;
      end
      if (cmd_i.scr_en) begin
        last_q <= now_q;
      end
    end
  end

  // slot walk
  logic                    pend_q, wv_q;
  logic signed [ACC_W-1:0] tx_q, ty_q;
  logic [CNT_W-1:0]        wcnt_q;

  always_ff @(posedge clk_i) begin
    pend_q <= cmd_i.walk_rd;
    if (cmd_i.walk_rd) begin
      wv_q <= present_q[cmd_i.walk_idx] & pvalid_q[cmd_i.walk_idx];
    end
    if (cmd_i.walk_clr) begin
      tx_q   <= '0;
      ty_q   <= '0;
      wcnt_q <= '0;
    end else if (pend_q && wv_q) begin
      tx_q   <= tx_q + ACC_W'($signed({1'b0, rd_cx_q}) - $signed({1'b0, rd_px_q}));
      ty_q   <= ty_q + ACC_W'($signed({1'b0, rd_cy_q}) - $signed({1'b0, rd_py_q}));
      wcnt_q <= wcnt_q + 1'b1;
    end
  end

  // scroll limit, divisor, axis select and serial quotient
  logic [DTC_W-1:0] dtc_q;
  logic [DEN_W-1:0] den_q;
  logic [LIM_W-1:0] lim_q;
  logic [ACC_W-1:0] mag_tx, mag_ty, rem_q;
  logic             hit_q;
  logic [DIR_W-1:0] dir_q;
  logic [QB_W-1:0]  quo_q;
  logic [TRL_W-1:0] trial;
  logic             y_hit, x_hit;

  assign mag_tx = tx_q[ACC_W-1] ? ACC_W'(-tx_q) : ACC_W'(tx_q);
  assign mag_ty = ty_q[ACC_W-1] ? ACC_W'(-ty_q) : ACC_W'(ty_q);
  assign y_hit  = 32'(mag_ty) > 32'(lim_q);
  assign x_hit  = 32'(mag_tx) > 32'(lim_q);
  assign trial  = TRL_W'(den_q) << cmd_i.div_bit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.dtc_en) begin
      dtc_q <= DTC_W'(dt_eff) * DTC_W'(wcnt_q);
    end
    if (cmd_i.den_en) begin
      den_q <= (DEN_W'(dtc_q) << 8) + (DEN_W'(dtc_q) << 6);
      lim_q <= LIM_W'(wcnt_q) * LIM_W'(4'd10) * LIM_W'(scroll_thr_q);
    end
    if (cmd_i.sel_en) begin
      quo_q <= '0;
      if (y_hit) begin
        hit_q <= 1'b1;
        dir_q <= (ty_q > 0) ? DIR_UP : DIR_DOWN;
        rem_q <= mag_ty;
      end else begin
        hit_q <= x_hit;
        dir_q <= (tx_q < 0) ? DIR_LEFT : DIR_RIGHT;
        rem_q <= mag_tx;
      end
    end
    if (cmd_i.div_en && (TRL_W'(rem_q) >= trial)) begin
      rem_q                <= rem_q - trial[ACC_W-1:0];
      quo_q[cmd_i.div_bit] <= 1'b1;
    end
  end

  // per-event result
  logic             res_valid_q;
  logic [DIR_W-1:0] res_dir_q;
  logic [AMT_W-1:0] res_amt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_load) begin
      res_valid_q <= 1'b0;
      res_dir_q   <= '0;
      res_amt_q   <= '0;
    end else if (cmd_i.scr_en && hit_q) begin
      res_valid_q <= 1'b1;
      res_dir_q   <= dir_q;
      if (quo_q > QB_W'(AMOUNT_MAX)) begin
        res_amt_q <= AMOUNT_MAX;
      end else if (quo_q == '0) begin
        res_amt_q <= AMT_W'(1);
      end else begin
        res_amt_q <= quo_q[AMT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      scroll_valid_o     <= res_valid_q;
      scroll_direction_o <= res_dir_q;
      scroll_amount_o    <= res_amt_q;
      gesture_active_o   <= active_q;
    end
  end

  // status
  assign sts_o.kind    = kind_q;
  assign sts_o.slot_ok = 7'(slot_q) < 7'(SLOTS);
  assign sts_o.move_ok = 8'(count_q) == 8'(fingers_q);
  assign sts_o.tmr_ok  = active_q && (dt >= TIME_W'(min_int_q));

endmodule

`default_nettype wire

// ===== hw/rtl/mtsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtsg_ctrl
// sequencer for one event: decode, slot update, activation test, slot walk,
// quotient steps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module mtsg_ctrl
  import mtsg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire mtsg_sts_t sts_i,
  output mtsg_cmd_t      cmd_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DEC  = 5'd1;
  localparam logic [4:0] ST_MRD  = 5'd2;
  localparam logic [4:0] ST_MUPD = 5'd3;
  localparam logic [4:0] ST_SQX  = 5'd4;
  localparam logic [4:0] ST_SQY  = 5'd5;
  localparam logic [4:0] ST_TSQ  = 5'd6;
  localparam logic [4:0] ST_ACT  = 5'd7;
  localparam logic [4:0] ST_TCHK = 5'd8;
  localparam logic [4:0] ST_WALK = 5'd9;
  localparam logic [4:0] ST_WEND = 5'd10;
  localparam logic [4:0] ST_DTC  = 5'd11;
  localparam logic [4:0] ST_DEN  = 5'd12;
  localparam logic [4:0] ST_SEL  = 5'd13;
  localparam logic [4:0] ST_DIV  = 5'd14;
  localparam logic [4:0] ST_SCR  = 5'd15;
  localparam logic [4:0] ST_FIN  = 5'd16;

  logic [4:0]        state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    bit_d   = bit_q;
    cmd_o   = '0;
    cmd_o.walk_idx = idx_q;
    cmd_o.div_bit  = bit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ev_load = 1'b1;
          state_d       = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_FIN;
        if (sts_i.slot_ok) begin
          case (sts_i.kind)
            KIND_DOWN: cmd_o.do_down = 1'b1;
            KIND_UP:   cmd_o.do_up   = 1'b1;
            KIND_MOVE: begin
              if (sts_i.move_ok) begin
                cmd_o.rd_ev = 1'b1;
                state_d     = ST_MRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MRD: state_d = ST_MUPD;
      ST_MUPD: begin
        cmd_o.do_move = 1'b1;
        state_d       = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQX;
        state_d       = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQY;
        state_d       = ST_TSQ;
      end
      ST_TSQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TSQ;
        state_d       = ST_ACT;
      end
      ST_ACT: begin
        cmd_o.act_cmp = 1'b1;
        state_d       = ST_TCHK;
      end
      ST_TCHK: begin
        if (sts_i.tmr_ok) begin
          cmd_o.walk_clr = 1'b1;
          idx_d          = '0;
          state_d        = ST_WALK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_WALK: begin
        cmd_o.walk_rd = 1'b1;
        if (idx_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_WEND;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_WEND: state_d = ST_DTC;
      ST_DTC: begin
        cmd_o.dtc_en = 1'b1;
        state_d      = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.den_en = 1'b1;
        state_d      = ST_SEL;
      end
      ST_SEL: begin
        cmd_o.sel_en = 1'b1;
        bit_d        = BIT_W'(QB_W - 1);
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        if (bit_q == '0) begin
          state_d = ST_SCR;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      ST_SCR: begin
        cmd_o.scr_en = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      bit_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      bit_q    <= bit_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_touch_scroll_gesture.sv =====
// ----------------------------------------------------------------------------
// multi_touch_scroll_gesture
// multi-finger scroll recogniser: tracks touch slots, activates on summed
// motion and emits rate-limited scroll requests with direction and intensity
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------------------
//  in        in_valid_i/in_ready_o   kind, slot, pos_x, pos_y, time_ms
//  out       out_valid_o/out_ready_i scroll_valid, scroll_direction,
//                                    scroll_amount, gesture_active
//  cfg       cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
//  every request yields exactly one result request
//  down, up and ignored events pass decode and the final state; motion adds
//  slot read and update, the squares, activation and timer checks; a scroll
//  try adds the 16-slot walk and 5 quotient steps
//  a new request is taken while the previous result waits in the output
//  register; a stalled output holds the sequencer in its final state
//  reset clears slot flags, counts, sums and timers; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module multi_touch_scroll_gesture
  import mtsg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // event requests
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [SIN_W-1:0]      slot_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  input  wire logic [TIME_W-1:0]     time_ms_i,
  // result requests
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       scroll_valid_o,
  output logic [DIR_W-1:0]           scroll_direction_o,
  output logic [AMT_W-1:0]           scroll_amount_o,
  output logic                       gesture_active_o,
  // register writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  mtsg_cmd_t cmd;
  mtsg_sts_t sts;

  // sequencer: one event at a time, output register decoupled
  mtsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: slot store, sums, multiplier, walk and quotient unit
  mtsg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kind_i             (kind_i),
    .slot_i             (slot_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .time_ms_i          (time_ms_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .scroll_valid_o     (scroll_valid_o),
    .scroll_direction_o (scroll_direction_o),
    .scroll_amount_o    (scroll_amount_o),
    .gesture_active_o   (gesture_active_o)
  );

endmodule

`default_nettype wire
